### sv/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg
// Shared constants for the Mandelbrot escape-time counter: fixed-point
// format, product widths and the escape threshold.
// ----------------------------------------------------------------------------
package mec_pkg;

  // Operand and register widths.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned PROD_W  = 2 * COORD_W;
  localparam int unsigned COUNT_W = 16;

  // Number of fractional bits in the fixed-point format of c and z.
  localparam int unsigned FRAC_BITS = 28;

  // Width of the update sums: a shifted product plus a coordinate, with headroom.
  localparam int unsigned SUM_W = PROD_W + 2;

  // Reset value of the iteration limit.
  localparam logic [COUNT_W-1:0] MAX_ITER_RESET = COUNT_W'(256);

  // |z|^2 >= 4 means the sum of squares reaches 2^(2*FRAC_BITS+2). When that
  // bit lies beyond the product width, a point can never escape.
  localparam int unsigned ESC_SHIFT  = 2 * FRAC_BITS + 2;
  localparam bit          CAN_ESCAPE = (ESC_SHIFT < PROD_W);
  localparam logic [PROD_W:0] ESC_THR =
      CAN_ESCAPE ? ((PROD_W + 1)'(1) << ESC_SHIFT) : '0;

  // Saturation bounds of a z component.
  localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'((64'(1) << (COORD_W - 1)) - 64'(1));
  localparam logic signed [SUM_W-1:0] COORD_MIN = -(SUM_W'(64'(1) << (COORD_W - 1)));

endpackage

### sv/mandelbrot_escape_count_core.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_core
// Escape-time counter: iterates z = z*z + c from z = 0 on one point and
// returns how many iterations ran before |z|^2 reached 4 or the limit hit.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                          Handshake
//  --------  -----------------------------  ------------------------------------
//  config    cfg_we, cfg_wdata[15:0]        write when cfg_we is high
//  point     start, c_real, c_imag / busy   taken when start && !busy
//  result    done, iteration_count[15:0]    one-cycle strobe on done
//
// An iteration works around a single 32x32 signed multiplier, in order:
// x*x, then y*y, then x*y together with the escape test, then the update of
// z. busy is high from the accepting edge until done rises and falls in the
// cycle in which done is asserted, so the next point can start right then.
// The result receiver cannot stall the block. Reset (synchronous, active high)
// returns the sequencer to idle and sets the iteration limit to 256.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mec_pkg::COUNT_W-1:0]          cfg_wdata,
  input  logic                                 start,
  input  logic signed [mec_pkg::COORD_W-1:0]   c_real,
  input  logic signed [mec_pkg::COORD_W-1:0]   c_imag,
  output logic                                 busy,
  output logic                                 done,
  output logic [mec_pkg::COUNT_W-1:0]          iteration_count
);

  // The sequencer steps through the three products of an iteration and then
  // the update. The escape test sits in the x*y step, where both squares are
  // already registered.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_MUL_XY,
    ST_UPDATE
  } state_t;

  state_t state;

  // Iteration limit.
  logic [mec_pkg::COUNT_W-1:0] iter_limit;

  // Point under work and the current z.
  logic signed [mec_pkg::COORD_W-1:0] cr;
  logic signed [mec_pkg::COORD_W-1:0] ci;
  logic signed [mec_pkg::COORD_W-1:0] x;
  logic signed [mec_pkg::COORD_W-1:0] y;
  logic [mec_pkg::COUNT_W-1:0]        count;

  // Registered products.
  logic signed [mec_pkg::PROD_W-1:0] xx;
  logic signed [mec_pkg::PROD_W-1:0] yy;
  logic signed [mec_pkg::PROD_W-1:0] xy;
  logic signed [mec_pkg::PROD_W-1:0] diff;

  // Shared multiplier and its operand select.
  logic signed [mec_pkg::COORD_W-1:0] mult_a;
  logic signed [mec_pkg::COORD_W-1:0] mult_b;
  logic signed [mec_pkg::PROD_W-1:0]  product;

  // Escape test and update datapath.
  logic [mec_pkg::PROD_W:0]          mag;
  logic                              finished;
  logic signed [mec_pkg::PROD_W-1:0] re_shift;
  logic signed [mec_pkg::PROD_W-1:0] im_shift;
  logic signed [mec_pkg::SUM_W-1:0]  re_sum;
  logic signed [mec_pkg::SUM_W-1:0]  im_sum;
  logic signed [mec_pkg::COORD_W-1:0] x_next;
  logic signed [mec_pkg::COORD_W-1:0] y_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    unique case (state)
      ST_MUL_XX: begin
        mult_a = x;
        mult_b = x;
      end
      ST_MUL_YY: begin
        mult_a = y;
        mult_b = y;
      end
      default: begin
        mult_a = x;
        mult_b = y;
      end
    endcase
  end

  assign product = mult_a * mult_b;

  // Both squares are non-negative and at most 2^62, so the sum is exact.
  assign mag = {1'b0, xx} + {1'b0, yy};
  assign finished = (count >= iter_limit) ||
                    (mec_pkg::CAN_ESCAPE && (mag >= mec_pkg::ESC_THR));

  // Arithmetic shifts round toward minus infinity. The cross product is
  // shifted one place less, which doubles it.
  assign re_shift = diff >>> mec_pkg::FRAC_BITS;
  assign im_shift = xy >>> (mec_pkg::FRAC_BITS - 1);
  assign re_sum   = mec_pkg::SUM_W'(re_shift) + mec_pkg::SUM_W'(cr);
  assign im_sum   = mec_pkg::SUM_W'(im_shift) + mec_pkg::SUM_W'(ci);

  always_comb begin
    priority if (re_sum > mec_pkg::COORD_MAX) begin
      x_next = mec_pkg::COORD_W'(mec_pkg::COORD_MAX);
    end else if (re_sum < mec_pkg::COORD_MIN) begin
      x_next = mec_pkg::COORD_W'(mec_pkg::COORD_MIN);
    end else begin
      x_next = mec_pkg::COORD_W'(re_sum);
    end
    priority if (im_sum > mec_pkg::COORD_MAX) begin
      y_next = mec_pkg::COORD_W'(mec_pkg::COORD_MAX);
    end else if (im_sum < mec_pkg::COORD_MIN) begin
      y_next = mec_pkg::COORD_W'(mec_pkg::COORD_MIN);
    end else begin
      y_next = mec_pkg::COORD_W'(im_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      iter_limit <= mec_pkg::MAX_ITER_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        iter_limit <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cr    <= c_real;
            ci    <= c_imag;
            x     <= '0;
            y     <= '0;
            count <= '0;
            state <= ST_MUL_XX;
          end
        end
        ST_MUL_XX: begin
          xx    <= product;
          state <= ST_MUL_YY;
        end
        ST_MUL_YY: begin
          yy    <= product;
          state <= ST_MUL_XY;
        end
        ST_MUL_XY: begin
          xy   <= product;
          diff <= xx - yy;
          if (finished) begin
            done            <= 1'b1;
            iteration_count <= count;
            state           <= ST_IDLE;
          end else begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          x     <= x_next;
          y     <= y_next;
          count <= count + mec_pkg::COUNT_W'(1);
          state <= ST_MUL_XX;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/tb_mandelbrot_escape_count_core.sv
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_count_core
// Self-checking testbench for the escape-time counter. It sends points in
// Q4.28 format, predicts each iteration count with a fixed-point model of
// z = z*z + c, and compares every done strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_count_core;

  timeunit 1ns;
  timeprecision 1ps;

  // One unit in Q4.28, used to write directed points in readable form.
  localparam int ONE_Q = 1 << mec_pkg::FRAC_BITS;

  // |z|^2 >= 4 in the squared format (2*FRAC_BITS fraction bits). If that
  // bit falls outside 64 bits, no point can ever escape.
  localparam int unsigned ESC_BIT = 2 * mec_pkg::FRAC_BITS + 2;
  localparam bit ESC_REACHABLE = (ESC_BIT < 64);
  localparam longint unsigned ESC_MAG = ESC_REACHABLE ? (64'd1 << ESC_BIT) : 64'd0;

  // Clamp bounds of a z component.
  localparam longint Z_HI = 64'sd2147483647;
  localparam longint Z_LO = -64'sd2147483648;

  localparam logic signed [mec_pkg::COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [mec_pkg::COORD_W-1:0] C_MIN = 32'sh8000_0000;

  // The longest legal point runs 65535 iterations with nothing accepted; the
  // watchdog allows about four of those.
  localparam int unsigned WATCHDOG_LIMIT = 1_100_000;
  localparam int unsigned SETTLE_CAP     = 1_100;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                cfg_we    = 1'b0;
  logic [mec_pkg::COUNT_W-1:0]         cfg_wdata = '0;
  logic                                start     = 1'b0;
  logic signed [mec_pkg::COORD_W-1:0]  c_real    = '0;
  logic signed [mec_pkg::COORD_W-1:0]  c_imag    = '0;
  logic                                busy;
  logic                                done;
  logic [mec_pkg::COUNT_W-1:0]         iteration_count;

  // Counts predicted for accepted points, oldest first.
  logic [mec_pkg::COUNT_W-1:0] pending_counts[$];

  // Shadow of the iteration limit register.
  logic [mec_pkg::COUNT_W-1:0] iter_limit = mec_pkg::MAX_ITER_RESET;

  // When set, the sender inserts random gaps between transactions.
  bit          sender_gaps    = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned points_sent    = 0;
  int unsigned results_seen   = 0;
  int unsigned idle_cycles    = 0;
  int unsigned limits_used    = 0;

  mandelbrot_escape_count_core uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .c_real          (c_real),
    .c_imag          (c_imag),
    .busy            (busy),
    .done            (done),
    .iteration_count (iteration_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic longint clamp_coord(input longint v);
    if (v > Z_HI) return Z_HI;
    if (v < Z_LO) return Z_LO;
    return v;
  endfunction

  // Iterates z = z*z + c from zero in exact 64-bit fixed point. The escape
  // test runs before every iteration, so the count stops as soon as |z|^2
  // reaches 4 or the limit is hit. Products are rounded toward minus
  // infinity by an arithmetic shift; the cross term keeps one extra bit
  // because it stands for 2*x*y.
  function automatic logic [mec_pkg::COUNT_W-1:0] escape_count(
      input logic signed [mec_pkg::COORD_W-1:0] cr,
      input logic signed [mec_pkg::COORD_W-1:0] ci,
      input logic [mec_pkg::COUNT_W-1:0]        limit);
    longint x, y, xx, yy, xy;
    longint unsigned mag;
    logic [mec_pkg::COUNT_W-1:0] n;
    x = 0;
    y = 0;
    n = '0;
    while (n < limit) begin
      xx  = x * x;
      yy  = y * y;
      mag = longint'(xx) + longint'(yy);
      if (ESC_REACHABLE && mag >= ESC_MAG) break;
      xy = x * y;
      x  = clamp_coord(((xx - yy) >>> mec_pkg::FRAC_BITS) + longint'(cr));
      y  = clamp_coord((xy >>> (mec_pkg::FRAC_BITS - 1)) + longint'(ci));
      n++;
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking. done is sampled just before the edge that accepts the
  // result, so the comparison never races with the block's own updates.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [mec_pkg::COUNT_W-1:0] want;
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (pending_counts.size() == 0) begin
        $error("unexpected result: iteration_count %0d with no point outstanding",
               iteration_count);
        mismatch_count++;
      end else begin
        want = pending_counts.pop_front();
        if (iteration_count !== want) begin
          $error("iteration_count mismatch: expected %0d, actual %0d", want,
                 iteration_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any accepted transaction, on either side, restarts the count.
  always @(posedge clk) begin
    if (rst || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks. All of them run on rising edges and use nonblocking
  // assignments, and each returns right after an edge.
  // --------------------------------------------------------------------------

  // Presents one point and holds it until the block takes it. start stays
  // high into the next call unless a gap is inserted.
  task automatic send_point(input logic signed [mec_pkg::COORD_W-1:0] cr,
                            input logic signed [mec_pkg::COORD_W-1:0] ci);
    int unsigned gap;
    start  <= 1'b1;
    c_real <= cr;
    c_imag <= ci;
    do @(posedge clk); while (busy !== 1'b0);
    pending_counts.push_back(escape_count(cr, ci, iter_limit));
    points_sent++;
    if (sender_gaps && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 18);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every predicted count has come back and the block is idle.
  // At least one edge passes, so no later call assigns start in this step.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_counts.size() != 0 || busy !== 1'b0);
  endtask

  // The limit is only written while nothing is in flight.
  task automatic set_iteration_limit(input logic [mec_pkg::COUNT_W-1:0] limit);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we     <= 1'b0;
    iter_limit  = limit;
    limits_used++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Limit left at its reset value: points inside the set, on the escape
  // circle, at the cusp, one just outside it, and one near the neck.
  task automatic test_reset_limit();
    send_point(0, 0);
    send_point(-ONE_Q, 0);
    send_point(0, ONE_Q);
    send_point(-2 * ONE_Q, 0);
    send_point(ONE_Q / 4, 0);
    send_point(ONE_Q / 4 + ONE_Q / 100, 0);
    send_point(-3 * ONE_Q / 4, ONE_Q / 10);
  endtask

  // Field extremes: corners and edges of the coordinate range and the smallest
  // steps around zero.
  task automatic test_extreme_points();
    send_point(C_MIN, C_MIN);
    send_point(C_MAX, C_MAX);
    send_point(C_MIN, C_MAX);
    send_point(C_MAX, C_MIN);
    send_point(0, C_MIN);
    send_point(C_MAX, 0);
    send_point(-1, -1);
    send_point(1, 1);
  endtask

  // A zero limit must report zero iterations for any point.
  task automatic test_zero_limit();
    set_iteration_limit('0);
    send_point(0, 0);
    send_point(C_MIN, C_MAX);
  endtask

  // Smallest and largest limits. Under the largest one, a point inside the
  // set runs the full 65535 iterations and a point near the neck of the set
  // escapes only after a few hundred.
  task automatic test_limit_extremes();
    set_iteration_limit(mec_pkg::COUNT_W'(1));
    send_point(0, 0);
    send_point(C_MIN, C_MIN);
    set_iteration_limit('1);
    send_point(C_MIN, C_MIN);
    send_point(ONE_Q / 4 + ONE_Q / 100, 0);
    send_point(-3 * ONE_Q / 4, ONE_Q / 100);
    send_point(0, 0);
  endtask

  // Random points under one limit. Most fall in the box around the set, so
  // counts spread over the whole range; some come from the slow regions near
  // the neck and the cusp, and the rest use the full 32-bit range.
  task automatic test_random_points(input logic [mec_pkg::COUNT_W-1:0] limit,
                                    input int unsigned n, input bit gaps);
    int unsigned pick;
    logic signed [mec_pkg::COORD_W-1:0] cr, ci;
    set_iteration_limit(limit);
    sender_gaps = gaps;
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        cr = -(9 * (ONE_Q / 4)) + int'($urandom_range(0, 3 * ONE_Q));
        ci = -(5 * ONE_Q / 4) + int'($urandom_range(0, 5 * ONE_Q / 2));
      end else if (pick < 15) begin
        cr = -(3 * ONE_Q / 4) + int'($urandom_range(0, ONE_Q / 8)) - ONE_Q / 16;
        ci = int'($urandom_range(0, 2 * ONE_Q / 5)) - ONE_Q / 5;
      end else if (pick < 17) begin
        cr = ONE_Q / 5 + int'($urandom_range(0, ONE_Q / 10));
        ci = int'($urandom_range(0, ONE_Q / 10)) - ONE_Q / 20;
      end else begin
        cr = $urandom;
        ci = $urandom;
      end
      send_point(cr, ci);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned settle;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: no gaps, so the first points follow back to back.
    sender_gaps = 1'b0;
    test_reset_limit();
    test_extreme_points();
    test_zero_limit();
    test_limit_extremes();

    // Random part. The middle contains a stretch without gaps, and the
    // final phase runs without any idling at all.
    test_random_points(mec_pkg::COUNT_W'(1), 150, 1'b1);
    test_random_points(mec_pkg::COUNT_W'(33), 300, 1'b1);
    test_random_points(mec_pkg::COUNT_W'(64), 350, 1'b0);
    test_random_points(mec_pkg::COUNT_W'(255), 300, 1'b1);
    repeat (6) test_random_points(mec_pkg::COUNT_W'($urandom_range(2, 120)), 50, 1'b1);
    test_random_points(mec_pkg::COUNT_W'(100), 250, 1'b0);

    drain_results();

    // Give a stray late result time to show up before the verdict.
    settle = 4 * int'(iter_limit) + 8;
    if (settle > SETTLE_CAP) settle = SETTLE_CAP;
    repeat (settle) @(posedge clk);

    if (pending_counts.size() != 0) begin
      $error("%0d predicted results never arrived", pending_counts.size());
      mismatch_count++;
    end

    $display("Covered %0d points under %0d limit settings, from zero to 65535.",
             points_sent, limits_used);
    $display("Compared %0d results, %0d mismatches.", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
